FILE: src/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants of the prefix-code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  localparam int unsigned ALPHABET_SIZE = 128;
  localparam int unsigned MAX_CODE_LEN  = 32;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned CODE_W        = 32;
  localparam int unsigned LEN_IN_W      = 6;
  localparam int unsigned IDX_W         = $clog2(ALPHABET_SIZE);
  localparam int unsigned LEN_W         = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned PAD_W         = $clog2(BYTE_W);
  localparam int unsigned ACC_W         = MAX_CODE_LEN + BYTE_W - 1;
  localparam int unsigned TOT_W         = $clog2(ACC_W + 1);
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_IN_W-1:0] code_length;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_pad_count;
    logic              last;
  } out_t;

  typedef struct packed {
    logic                    fin;
    logic [MAX_CODE_LEN-1:0] bits;
    logic [LEN_W-1:0]        len;
  } item_t;

endpackage

FILE: src/pcbp_front.sv
// ----------------------------------------------------------------------------
// pcbp_front
// Accepts items, holds the code table and turns symbols into code words.
// ----------------------------------------------------------------------------
module pcbp_front import pcbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output item_t q_item_o
);

  typedef struct packed {
    logic [MAX_CODE_LEN-1:0] bits;
    logic [LEN_W-1:0]        len;
  } entry_t;

  entry_t                   mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] vld_q;
  entry_t                   rd_q;
  logic                     rd_vld_q;
  logic                     s1_valid_q;
  logic                     s1_fin_q;
  logic                     s1_inrange_q;

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] len_sat;
  logic [MAX_CODE_LEN-1:0] mask;
  logic             hit;
  logic             drop;
  logic             s1_done;

  assign in_range = ({1'b0, in_i.symbol} < (SYM_W + 1)'(ALPHABET_SIZE));
  assign idx      = in_i.symbol[IDX_W-1:0];
  assign len_sat  = (in_i.code_length > LEN_IN_W'(MAX_CODE_LEN)) ?
                    LEN_W'(MAX_CODE_LEN) : LEN_W'(in_i.code_length);
  assign mask     = ~({MAX_CODE_LEN{1'b1}} << len_sat);

  assign hit      = rd_vld_q && s1_inrange_q;
  assign q_item_o.fin  = s1_fin_q;
  assign q_item_o.bits = hit ? rd_q.bits : '0;
  assign q_item_o.len  = hit ? rd_q.len  : '0;

  assign drop       = !s1_fin_q && (q_item_o.len == '0);
  assign q_valid_o  = s1_valid_q && !drop;
  assign s1_done    = s1_valid_q && (drop || q_ready_i);
  assign in_ready_o = !s1_valid_q || s1_done;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept && in_range && (in_i.opcode == OP_WRITE)) begin
      mem[idx] <= '{bits: MAX_CODE_LEN'(in_i.code_bits) & mask, len: len_sat};
    end
    if (accept) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      rd_vld_q     <= 1'b0;
      s1_valid_q   <= 1'b0;
      s1_fin_q     <= 1'b0;
      s1_inrange_q <= 1'b0;
    end else begin
      if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (accept) begin
        rd_vld_q     <= vld_q[idx];
        s1_inrange_q <= in_range;
        case (in_i.opcode)
          OP_WRITE: begin
            if (in_range) begin
              vld_q[idx] <= 1'b1;
            end
          end
          OP_ENCODE: begin
            s1_valid_q <= 1'b1;
            s1_fin_q   <= 1'b0;
          end
          OP_FINISH: begin
            s1_valid_q <= 1'b1;
            s1_fin_q   <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: src/pcbp_queue.sv
// ----------------------------------------------------------------------------
// pcbp_queue
// Short queue of code words between the front and the packer.
// ----------------------------------------------------------------------------
module pcbp_queue import pcbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_item_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  logic push;
  logic pop;

  assign wr_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = buf_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/pcbp_back.sv
// ----------------------------------------------------------------------------
// pcbp_back
// Bit packer: appends code words to the pending bits and emits bytes.
// ----------------------------------------------------------------------------
module pcbp_back import pcbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  output logic  q_ready_o,
  input  item_t q_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_o
);

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_DATA,
    FIN_PAD
  } fin_e;

  fin_e             fin_q;
  logic [ACC_W-1:0] acc_q;
  logic [TOT_W-1:0] tot_q;
  logic [PAD_W-1:0] pad_q;
  logic             out_valid_q;
  out_t             out_q;

  logic             out_free;
  logic             has_byte;
  logic             can_pop;
  logic             pop;
  logic [TOT_W-1:0] sh;
  logic [TOT_W-1:0] rem;
  logic [ACC_W-1:0] acc_shr;
  logic [ACC_W-1:0] acc_shl;
  logic [BYTE_W-1:0] fin_byte;

  assign out_free = !out_valid_q || out_ready_i;
  assign has_byte = (tot_q >= TOT_W'(BYTE_W));
  assign sh       = tot_q - TOT_W'(BYTE_W);
  assign rem      = has_byte ? sh : tot_q;
  assign acc_shr  = acc_q >> sh;
  assign acc_shl  = acc_q << q_item_i.len;
  assign fin_byte = acc_q[BYTE_W-1:0] << pad_q;
  assign can_pop  = (fin_q == FIN_NONE) &&
                    (!has_byte || (out_free && (tot_q < TOT_W'(2 * BYTE_W))));
  assign q_ready_o = can_pop;
  assign pop       = q_valid_i && can_pop;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q       <= FIN_NONE;
      acc_q       <= '0;
      tot_q       <= '0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (fin_q)
        FIN_NONE: begin
          if (has_byte && out_free) begin
            out_valid_q        <= 1'b1;
            out_q.out_byte     <= acc_shr[BYTE_W-1:0];
            out_q.is_pad_count <= 1'b0;
            out_q.last         <= (sh < TOT_W'(BYTE_W));
            tot_q              <= sh;
          end
          if (pop) begin
            if (q_item_i.fin) begin
              tot_q <= rem;
              if (rem != '0) begin
                fin_q <= FIN_DATA;
                pad_q <= PAD_W'(TOT_W'(BYTE_W) - rem);
              end else begin
                fin_q <= FIN_PAD;
                pad_q <= '0;
              end
            end else begin
              acc_q <= acc_shl | ACC_W'(q_item_i.bits);
              tot_q <= rem + TOT_W'(q_item_i.len);
            end
          end
        end
        FIN_DATA: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.out_byte     <= fin_byte;
            out_q.is_pad_count <= 1'b0;
            out_q.last         <= 1'b0;
            tot_q              <= '0;
            fin_q              <= FIN_PAD;
          end
        end
        FIN_PAD: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.out_byte     <= BYTE_W'(pad_q);
            out_q.is_pad_count <= 1'b1;
            out_q.last         <= 1'b1;
            tot_q              <= '0;
            fin_q              <= FIN_NONE;
          end
        end
        default: begin
          fin_q <= FIN_NONE;
        end
      endcase
    end
  end

endmodule

FILE: src/prefix_code_bit_packer.sv
// ----------------------------------------------------------------------------
// prefix_code_bit_packer: table-driven prefix-code encoder and byte packer.
// A symbol's first byte passes the front's table read, the queue, the packer's
// pending bits and its output register. One item per cycle unless stalled; the
// packer takes none during a finish or while pending bytes wait for output.
// Reset clears the table valid bits and the pending bits at once; no sweep.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer import pcbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;
  logic  qb_valid;
  logic  qb_ready;
  item_t qb_item;

  pcbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_item_o   (fq_item)
  );

  pcbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_item_i  (fq_item),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_item_o  (qb_item)
  );

  pcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_item_i    (qb_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
